// File: design/spk_pkg.sv
// Shared types and constants for the SPH pair kernel unit.
// Used by the front end, the item queue, the back-end pipeline and the top level.
package spk_pkg;

    localparam int IN_W  = 48;
    localparam int OUT_W = 128;
    localparam int CFG_W = 32;

    localparam logic [1:0] CFG_IDX_RADIUS = 2'd0;
    localparam logic [1:0] CFG_IDX_WCOEF  = 2'd1;
    localparam logic [1:0] CFG_IDX_GCOEF  = 2'd2;

    localparam logic [14:0] RADIUS_RESET = 15'd4096;
    localparam logic [29:0] RADIUS_SQ_RESET = 30'd16777216;
    localparam logic [31:0] WCOEF_RESET  = 32'd26284540;
    localparam logic [31:0] GCOEF_RESET  = 32'd240315920;

    // Pipeline geometry of the back end.
    localparam int SQRT_STAGES = 15;
    localparam int DIV_STAGES  = 62;
    localparam int W_READY     = 4;

    typedef struct packed {
        logic [14:0] h;
        logic [29:0] h2;
        logic [31:0] wc;
        logic [31:0] gc;
    } t_cfg;

    typedef struct packed {
        logic            in_support;
        logic [29:0]     sq;
        logic [2:0][15:0] mag;
        logic [2:0]      neg;
    } t_item;

    typedef struct packed {
        logic            in_support;
        logic [2:0][15:0] mag;
        logic [2:0]      neg;
    } t_side;

endpackage

// File: design/spk_front.sv
// Front end: registers one offset word, squares and sums its components and
// classifies it against the support radius. Depends on spk_pkg.
module spk_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [spk_pkg::IN_W-1:0] i_data,
    output logic                     o_ready,
    input  logic [29:0]              i_h2,
    input  logic                     i_q_full,
    output logic                     o_push,
    output spk_pkg::t_item           o_item
);
    import spk_pkg::*;

    logic             r_valid;
    logic [2:0][30:0] r_sq;
    logic [2:0][15:0] r_mag;
    logic [2:0]       r_neg;
    logic [2:0][15:0] mag;
    logic [2:0]       neg;
    logic [2:0][31:0] sqv;
    logic [31:0]      s;
    logic             in_support;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            neg[c] = i_data[16*c+15];
            mag[c] = neg[c] ? 16'(-i_data[16*c +: 16]) : i_data[16*c +: 16];
            sqv[c] = 32'(mag[c]) * 32'(mag[c]);
        end
    end

    assign o_ready = !r_valid || !i_q_full;
    assign o_push  = r_valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            for (int c = 0; c < 3; c++) begin
                r_sq[c] <= sqv[c][30:0];
            end
            r_mag <= mag;
            r_neg <= neg;
        end
    end

    // Items outside the support carry a zero radicand so the root stays narrow.
    always_comb begin
        s = 32'(r_sq[0]) + 32'(r_sq[1]) + 32'(r_sq[2]);
        in_support = (s != 32'd0) && (s < {2'b00, i_h2});
        o_item.in_support = in_support;
        o_item.sq         = in_support ? s[29:0] : 30'd0;
        o_item.mag        = r_mag;
        o_item.neg        = r_neg;
    end

endmodule

// File: design/spk_queue.sv
// Short queue of classified items between the front end and the back end.
// Depends on spk_pkg for the item type.
module spk_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  spk_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output spk_pkg::t_item o_item
);
    import spk_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntW-1:0]  r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: design/spk_back.sv
// Back end: root, divider and multiplier pipeline that turns one classified
// item into the kernel weight and gradient. Depends on spk_pkg.
module spk_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  spk_pkg::t_cfg             i_cfg,
    input  logic                      i_q_valid,
    input  spk_pkg::t_item            i_q_item,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [spk_pkg::OUT_W-1:0] o_data,
    output logic                      o_user
);
    import spk_pkg::*;

    localparam int SideLen = SQRT_STAGES + 2 + DIV_STAGES;
    localparam int WLen    = SideLen - W_READY;
    localparam int Last    = SideLen + 2;

    logic [Last:0] r_vld;
    logic          en;

    // The whole back end moves as one; it halts only when its output word waits.
    assign en      = !r_vld[Last] || i_ready;
    assign o_pop   = en && i_q_valid;
    assign o_valid = r_vld[Last];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[Last-1:0], i_q_valid};
        end
    end

    t_item       r_s0;
    logic [29:0] r_d0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0 <= i_q_item;
            r_d0 <= i_cfg.h2 - i_q_item.sq;
        end
    end

    // Square root, two radicand bits per stage.
    logic [16:0] r_rem  [SQRT_STAGES];
    logic [14:0] r_root [SQRT_STAGES];
    logic [29:0] r_rad  [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
        logic [16:0] rem_in;
        logic [14:0] root_in;
        logic [29:0] rad_in;
        logic [18:0] cur;
        logic [18:0] trial;
        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = r_s0.sq;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
        end
        assign cur   = {rem_in, rad_in[29:28]};
        assign trial = {2'b00, root_in, 2'b01};
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (cur >= trial) begin
                    r_rem[k]  <= 17'(cur - trial);
                    r_root[k] <= {root_in[13:0], 1'b1};
                end else begin
                    r_rem[k]  <= cur[16:0];
                    r_root[k] <= {root_in[13:0], 1'b0};
                end
                r_rad[k] <= {rad_in[27:0], 2'b00};
            end
        end
    end

    logic [29:0] r_g1_esq;
    logic [14:0] r_g1_r;
    logic [14:0] e;
    logic [61:0] r_g2_p;
    logic [14:0] r_g2_r;

    assign e = i_cfg.h - r_root[SQRT_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g1_esq <= 30'(e) * 30'(e);
            r_g1_r   <= r_root[SQRT_STAGES-1];
            r_g2_p   <= 62'(i_cfg.gc) * 62'(r_g1_esq);
            r_g2_r   <= r_g1_r;
        end
    end

    // Restoring divider, one quotient bit per stage; quotient bits replace
    // dividend bits in the same word.
    logic [14:0] r_drem [DIV_STAGES];
    logic [61:0] r_dq   [DIV_STAGES];
    logic [14:0] r_dvs  [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        logic [14:0] rem_in;
        logic [61:0] dq_in;
        logic [14:0] dvs_in;
        logic [15:0] cur;
        logic [15:0] diff;
        logic        ge;
        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign dq_in  = r_g2_p;
            assign dvs_in = r_g2_r;
        end else begin : g_next
            assign rem_in = r_drem[k-1];
            assign dq_in  = r_dq[k-1];
            assign dvs_in = r_dvs[k-1];
        end
        assign cur  = {rem_in, dq_in[61]};
        assign ge   = cur >= {1'b0, dvs_in};
        assign diff = cur - {1'b0, dvs_in};
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_drem[k] <= ge ? diff[14:0] : cur[14:0];
                r_dq[k]   <= {dq_in[60:0], ge};
                r_dvs[k]  <= dvs_in;
            end
        end
    end

    // Weight path runs beside the root stages.
    logic [59:0] r_w1_dd;
    logic [29:0] r_w1_d;
    logic [59:0] r_w2_c;
    logic [61:0] r_w3_pl;
    logic [61:0] r_w3_ph;
    logic [31:0] r_w4;
    logic [91:0] wfull;

    assign wfull = {r_w3_ph, 30'd0} + {30'd0, r_w3_pl};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w1_dd <= 60'(r_d0) * 60'(r_d0);
            r_w1_d  <= r_d0;
            r_w2_c  <= 60'(r_w1_dd[59:30]) * 60'(r_w1_d);
            r_w3_pl <= 62'(i_cfg.wc) * 62'(r_w2_c[29:0]);
            r_w3_ph <= 62'(i_cfg.wc) * 62'(r_w2_c[59:30]);
            r_w4    <= (|wfull[91:82]) ? 32'hFFFF_FFFF : wfull[81:50];
        end
    end

    t_side       r_side [SideLen];
    logic [31:0] r_wl   [WLen];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0].in_support <= r_s0.in_support;
            r_side[0].mag        <= r_s0.mag;
            r_side[0].neg        <= r_s0.neg;
            for (int i = 1; i < SideLen; i++) begin
                r_side[i] <= r_side[i-1];
            end
            r_wl[0] <= r_w4;
            for (int i = 1; i < WLen; i++) begin
                r_wl[i] <= r_wl[i-1];
            end
        end
    end

    logic [2:0][46:0] r_m1_lo;
    logic [2:0][46:0] r_m1_hi;
    t_side            r_m1_side;
    logic [31:0]      r_m1_w;
    logic [61:0]      q;

    assign q = r_dq[DIV_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r_m1_lo[c] <= 47'(q[30:0]) * 47'(r_side[SideLen-1].mag[c]);
                r_m1_hi[c] <= 47'(q[61:31]) * 47'(r_side[SideLen-1].mag[c]);
            end
            r_m1_side <= r_side[SideLen-1];
            r_m1_w    <= r_wl[WLen-1];
        end
    end

    logic [2:0][77:0] gfull;
    logic [2:0][45:0] gm;
    logic [2:0][31:0] gres;

    // A positive component saturates its magnitude at 2^31 before negation,
    // a negative one at 2^31-1.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            gfull[c] = {r_m1_hi[c], 31'd0} + {31'd0, r_m1_lo[c]};
            gm[c]    = gfull[c][77:32];
            if (r_m1_side.neg[c]) begin
                gres[c] = (gm[c] > 46'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : gm[c][31:0];
            end else begin
                gres[c] = (gm[c] > 46'h0000_8000_0000) ? 32'h8000_0000
                                                       : 32'(-gm[c][31:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_m1_side.in_support) begin
                o_data <= {gres[2], gres[1], gres[0], r_m1_w};
            end else begin
                o_data <= '0;
            end
            o_user <= r_m1_side.in_support;
        end
    end

endmodule

// File: design/sph_pair_kernel_unit.sv
// Channel   | Dir | Word
// s_axis    | in  | tdata: offset_x, offset_y, offset_z (signed Q4.12)
// m_axis    | out | tdata: weight, gradient_x/y/z (Q16.16); tuser: within_support
// cfg       | in  | write enable, index, 32-bit data; no read-back
//
// One word per cycle is accepted and delivered when the output is not stalled.
// Most of a word's latency lies in the 62-stage divider and the
// 15-stage square root.
// Reset is synchronous, active low, and restores the default coefficients.
// A stalled output halts the back end; the front register and queue keep
// accepting until the queue fills.
module sph_pair_kernel_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [spk_pkg::IN_W-1:0]  i_s_axis_tdata,   // offset_x, offset_y, offset_z
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [spk_pkg::OUT_W-1:0] o_m_axis_tdata,   // weight, gradient_x, _y, _z
    output logic                      o_m_axis_tuser,   // within_support
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [spk_pkg::CFG_W-1:0] i_cfg_data
);
    import spk_pkg::*;

    logic [14:0] r_h;
    logic [29:0] r_h2;
    logic [31:0] r_wc;
    logic [31:0] r_gc;
    t_cfg        cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h  <= RADIUS_RESET;
            r_h2 <= RADIUS_SQ_RESET;
            r_wc <= WCOEF_RESET;
            r_gc <= GCOEF_RESET;
        end else begin
            r_h2 <= 30'(r_h) * 30'(r_h);
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_IDX_RADIUS: r_h  <= i_cfg_data[14:0];
                    CFG_IDX_WCOEF:  r_wc <= i_cfg_data;
                    CFG_IDX_GCOEF:  r_gc <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign cfg = '{h: r_h, h2: r_h2, wc: r_wc, gc: r_gc};

    logic  push;
    logic  q_full;
    t_item front_item;
    logic  q_valid;
    logic  q_pop;
    t_item q_item;

    spk_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_data   (i_s_axis_tdata),
        .o_ready  (o_s_axis_tready),
        .i_h2     (r_h2),
        .i_q_full (q_full),
        .o_push   (push),
        .o_item   (front_item)
    );

    spk_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    spk_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_pop     (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_data    (o_m_axis_tdata),
        .o_user    (o_m_axis_tuser)
    );

endmodule

// File: design/spk_checker.sv
// Port-level checks for the SPH pair kernel unit and the bind that attaches them.
// Depends on spk_pkg for port widths.
module spk_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_s_axis_tvalid,
    input logic                      o_s_axis_tready,
    input logic [spk_pkg::IN_W-1:0]  i_s_axis_tdata,
    input logic                      o_m_axis_tvalid,
    input logic                      i_m_axis_tready,
    input logic [spk_pkg::OUT_W-1:0] o_m_axis_tdata,
    input logic                      o_m_axis_tuser
);

    // A word held back by the sink keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output word changed while stalled");

    // An offered input word stays on the bus until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && !o_s_axis_tready |=>
            i_s_axis_tvalid && $stable(i_s_axis_tdata))
        else $error("input word changed while waiting");

    // Outside the support every result field is zero.
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("nonzero result outside support");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // The input side is ready in the cycle after each reset cycle.
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready)
        else $error("input not ready after reset");

endmodule

bind sph_pair_kernel_unit spk_checker u_spk_checker (.*);
